[hdl/png_su_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_su_pkg
// Shared constants and types for the PNG scanline unfilter unit.
// ----------------------------------------------------------------------------
package png_su_pkg;

  localparam int MAX_ROW_BYTES = 8192;
  localparam int MAX_BPP       = 8;

  localparam int ROW_AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int COL_W   = $clog2(MAX_ROW_BYTES + 1);
  localparam int HIST_IW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

  localparam int RB_W  = 14;
  localparam int BPP_W = 4;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic {
    REG_ROW_BYTES = 1'b0,
    REG_BPP       = 1'b1
  } reg_idx_e_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e_t;

  typedef struct packed {
    logic [7:0]         data;
    logic               is_type;
    logic               row_end;
    logic               bad;
    filt_e_t            filt;
    logic               has_left;
    logic               has_up;
    logic               up_ok;
    logic [HIST_IW-1:0] bpp_idx;
    logic [ROW_AW-1:0]  addr;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

endpackage

[hdl/png_su_row_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_su_row_ram
// Row store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module png_su_row_ram (
  input  logic                clk,
  input  png_su_pkg::rd_req_t rd,
  output logic [7:0]          rdata,
  input  png_su_pkg::wr_req_t wr
);

  logic [7:0] mem [png_su_pkg::MAX_ROW_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/png_su_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_su_ctrl
// Row sequencing: column count, filter type, error flag, row store read.
// ----------------------------------------------------------------------------
module png_su_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [7:0]                           data_byte,
  input  logic                                 frame_start,
  input  logic [png_su_pkg::RB_W-1:0]          row_bytes,
  input  logic [png_su_pkg::BPP_W-1:0]         bytes_per_pixel,
  output png_su_pkg::item_t                    item,
  output png_su_pkg::rd_req_t                  rd
);

  localparam int COL_W = png_su_pkg::COL_W;

  logic [COL_W-1:0]     col_r, col_nxt;
  logic [COL_W-1:0]     fill_r, fill_nxt;
  logic                 first_r, first_nxt;
  logic                 err_r, err_nxt;
  png_su_pkg::filt_e_t  filt_r, filt_nxt;

  logic [COL_W-1:0]     rb_eff;
  logic [png_su_pkg::BPP_W-1:0] bpp_eff;
  logic [COL_W-1:0]     col_eff;
  logic                 first_eff;
  logic                 err_eff;
  logic                 type_slot;
  logic                 bad_type;
  logic                 last;
  logic [png_su_pkg::ROW_AW-1:0] j;

  always_comb begin
    if (row_bytes == '0) begin
      rb_eff = COL_W'(1);
    end else if (32'(row_bytes) > 32'(png_su_pkg::MAX_ROW_BYTES)) begin
      rb_eff = COL_W'(png_su_pkg::MAX_ROW_BYTES);
    end else begin
      rb_eff = COL_W'(row_bytes);
    end
    if (bytes_per_pixel == '0) begin
      bpp_eff = png_su_pkg::BPP_W'(1);
    end else if (32'(bytes_per_pixel) > 32'(png_su_pkg::MAX_BPP)) begin
      bpp_eff = png_su_pkg::BPP_W'(png_su_pkg::MAX_BPP);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
  end

  always_comb begin
    col_eff   = frame_start ? '0 : col_r;
    first_eff = frame_start | first_r;
    err_eff   = ~frame_start & err_r;
    type_slot = (col_eff == '0);
    bad_type  = (data_byte > 8'(png_su_pkg::FILT_PAETH));
    j         = png_su_pkg::ROW_AW'(col_eff - COL_W'(1));
    last      = (col_eff >= rb_eff);
  end

  always_comb begin
    col_nxt   = col_r;
    fill_nxt  = fill_r;
    first_nxt = first_r;
    err_nxt   = err_r;
    filt_nxt  = filt_r;
    if (accept) begin
      first_nxt = first_eff;
      err_nxt   = err_eff;
      if (type_slot) begin
        col_nxt  = COL_W'(1);
        err_nxt  = err_eff | bad_type;
        filt_nxt = bad_type ? png_su_pkg::FILT_NONE : png_su_pkg::filt_e_t'(data_byte[2:0]);
      end else begin
        col_nxt = last ? '0 : col_eff + COL_W'(1);
        if (last) begin
          first_nxt = 1'b0;
        end
        if (col_eff > fill_r) begin
          fill_nxt = col_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      fill_r  <= '0;
      first_r <= 1'b1;
      err_r   <= 1'b0;
      filt_r  <= png_su_pkg::FILT_NONE;
    end else begin
      col_r   <= col_nxt;
      fill_r  <= fill_nxt;
      first_r <= first_nxt;
      err_r   <= err_nxt;
      filt_r  <= filt_nxt;
    end
  end

  always_comb begin
    item.data     = data_byte;
    item.is_type  = type_slot;
    item.row_end  = ~type_slot & last;
    item.bad      = type_slot ? (err_eff | bad_type) : err_eff;
    item.filt     = filt_r;
    item.has_left = (col_eff > COL_W'(bpp_eff));
    item.has_up   = ~first_eff;
    item.up_ok    = ~first_eff & (COL_W'(j) < fill_r);
    item.bpp_idx  = png_su_pkg::HIST_IW'(bpp_eff - png_su_pkg::BPP_W'(1));
    item.addr     = j;
    rd.en         = accept & ~type_slot;
    rd.addr       = j;
  end

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(png_su_pkg::MAX_ROW_BYTES))
    else $error("column beyond row store");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= COL_W'(png_su_pkg::MAX_ROW_BYTES))
    else $error("fill count beyond row store");
  a_fs_type: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_start |=> col_r == COL_W'(1) && first_r)
    else $error("frame start not taken as type byte");
`endif

endmodule

[hdl/png_su_recon.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_su_recon
// Reconstruction stage: predictor, left history and output register.
// ----------------------------------------------------------------------------
module png_su_recon (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  png_su_pkg::item_t   item,
  input  logic [7:0]          rdata,
  output logic                free,
  output png_su_pkg::wr_req_t wr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_is_type_byte,
  output logic                out_row_end,
  output logic                out_bad_filter
);

  localparam int HD = png_su_pkg::MAX_BPP;

  png_su_pkg::item_t s1_r;
  logic              s1_v_r, s1_v_nxt;
  logic              adv;
  logic              out_v_r, out_v_nxt;
  logic [7:0]        lh_r  [HD];
  logic [7:0]        ulh_r [HD];
  logic [7:0]        ob_r;
  logic              ot_r, oe_r, obad_r;

  logic [7:0] a, b, c, pred, res, pth;
  logic [8:0] avg_sum;
  logic signed [9:0] pa, pb, pc;

  function automatic logic signed [9:0] absv(input logic signed [9:0] x);
    absv = x[9] ? -x : x;
  endfunction

  assign adv  = s1_v_r & (~out_v_r | out_ready);
  assign free = ~s1_v_r | adv;

  always_comb begin
    a = s1_r.has_left ? lh_r[s1_r.bpp_idx] : 8'd0;
    b = s1_r.up_ok ? rdata : 8'd0;
    c = (s1_r.has_left & s1_r.has_up) ? ulh_r[s1_r.bpp_idx] : 8'd0;
    avg_sum = {1'b0, a} + {1'b0, b};
    pa = absv($signed({2'b00, b}) - $signed({2'b00, c}));
    pb = absv($signed({2'b00, a}) - $signed({2'b00, c}));
    pc = absv($signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0}));
    priority if (pa <= pb && pa <= pc) begin
      pth = a;
    end else if (pb <= pc) begin
      pth = b;
    end else begin
      pth = c;
    end
    unique case (s1_r.filt)
      png_su_pkg::FILT_SUB:   pred = a;
      png_su_pkg::FILT_UP:    pred = b;
      png_su_pkg::FILT_AVG:   pred = avg_sum[8:1];
      png_su_pkg::FILT_PAETH: pred = pth;
      default:                pred = 8'd0;
    endcase
    res = s1_r.data + pred;
  end

  always_comb begin
    wr.en   = adv & ~s1_r.is_type;
    wr.addr = s1_r.addr;
    wr.data = res;
  end

  always_comb begin
    s1_v_nxt  = accept ? 1'b1 : (adv ? 1'b0 : s1_v_r);
    out_v_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= item;
    end
    if (adv) begin
      ob_r   <= s1_r.is_type ? s1_r.data : res;
      ot_r   <= s1_r.is_type;
      oe_r   <= s1_r.row_end;
      obad_r <= s1_r.bad;
    end
    if (adv && !s1_r.is_type) begin
      lh_r[0]  <= res;
      ulh_r[0] <= b;
      for (int i = 1; i < HD; i++) begin
        lh_r[i]  <= lh_r[i-1];
        ulh_r[i] <= ulh_r[i-1];
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_byte         = ob_r;
  assign out_is_type_byte = ot_r;
  assign out_row_end      = oe_r;
  assign out_bad_filter   = obad_r;

`ifndef SYNTH
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r && $stable(s1_r))
    else $error("stage item lost while stalled");
  a_acc_free: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> free)
    else $error("item taken into busy stage");
  a_type_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_r.is_type |-> !s1_r.row_end && !wr.en)
    else $error("type byte marked as row end or stored");
`endif

endmodule

[hdl/png_scanline_unfilter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit
// PNG row filter reconstruction (None/Sub/Up/Average/Paeth), one byte per
// transfer, previous row held in a synchronous row store.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_ready  in_data_byte, in_frame_start
//   out_     out  out_valid/out_ready out_out_byte, out_is_type_byte,
//                                    out_row_end, out_bad_filter
//   cfg_     in   APB, pready high   0x0 row_bytes, 0x4 bytes_per_pixel
//
// One byte per cycle sustained while the output is not stalled; each byte passes
// the row store read, then the predictor stage into the output register.
// Reset needs no clearing pass: a fill count marks the row store columns
// written since reset, unwritten columns read as zero.
// A stalled output holds the predictor stage; input ready drops only then.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_out_byte,
  output logic                            out_is_type_byte,
  output logic                            out_row_end,
  output logic                            out_bad_filter,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [png_su_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [png_su_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [png_su_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                            cfg_pready
);

  logic [png_su_pkg::RB_W-1:0]  rb_r;
  logic [png_su_pkg::BPP_W-1:0] bpp_r;
  logic                         cfg_wr;
  png_su_pkg::reg_idx_e_t       cfg_idx;

  logic                accept;
  logic                free;
  png_su_pkg::item_t   item;
  png_su_pkg::rd_req_t rd;
  png_su_pkg::wr_req_t wr;
  logic [7:0]          rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = png_su_pkg::reg_idx_e_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r  <= png_su_pkg::RB_W'(1);
      bpp_r <= png_su_pkg::BPP_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        png_su_pkg::REG_ROW_BYTES: rb_r  <= cfg_pwdata[png_su_pkg::RB_W-1:0];
        png_su_pkg::REG_BPP:       bpp_r <= cfg_pwdata[png_su_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      png_su_pkg::REG_ROW_BYTES: cfg_prdata = png_su_pkg::CFG_DW'(rb_r);
      png_su_pkg::REG_BPP:       cfg_prdata = png_su_pkg::CFG_DW'(bpp_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  assign in_ready = free;
  assign accept   = in_valid & free;

  png_su_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .frame_start     (in_frame_start),
    .row_bytes       (rb_r),
    .bytes_per_pixel (bpp_r),
    .item            (item),
    .rd              (rd)
  );

  png_su_row_ram u_ram (
    .clk   (clk),
    .rd    (rd),
    .rdata (rdata),
    .wr    (wr)
  );

  png_su_recon u_recon (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .item             (item),
    .rdata            (rdata),
    .free             (free),
    .wr               (wr),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_out_byte),
    .out_is_type_byte (out_is_type_byte),
    .out_row_end      (out_row_end),
    .out_bad_filter   (out_bad_filter)
  );

endmodule
